// ===== rtl/core/moe_swiglu_expert_ffn_macros.svh =====
// Assertion macros used by the top-level module to check this block.
`ifndef MOE_SWIGLU_EXPERT_FFN_MACROS_SVH
`define MOE_SWIGLU_EXPERT_FFN_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MSEF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MSEF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/msef_pkg.sv =====
package msef_pkg;

	localparam int MAX_TOKENS  = 16;
	localparam int MAX_HIDDEN  = 64;
	localparam int MAX_INTER   = 64;
	localparam int MAX_EXPERTS = 8;
	localparam int MAX_TOPK    = 2;

	localparam int TOK_W   = $clog2(MAX_TOKENS);
	localparam int HID_W   = $clog2(MAX_HIDDEN);
	localparam int INTER_W = $clog2(MAX_INTER);
	localparam int EXP_W   = $clog2(MAX_EXPERTS);
	localparam int SLOT_W  = (MAX_TOPK > 1) ? $clog2(MAX_TOPK) : 1;
	localparam int IDX_W   = (HID_W > INTER_W) ? HID_W : INTER_W;

	localparam int TOK_AW   = TOK_W + HID_W;
	localparam int ROUTE_AW = TOK_W + SLOT_W;
	localparam int WGT_AW   = EXP_W + INTER_W + HID_W;
	localparam int OUT_AW   = TOK_W + HID_W;
	localparam int OUT_DEPTH = MAX_TOKENS * MAX_HIDDEN;

	// Configuration register indexes
	localparam logic [2:0] CFG_TOKENS  = 3'd0;
	localparam logic [2:0] CFG_HIDDEN  = 3'd1;
	localparam logic [2:0] CFG_INTER   = 3'd2;
	localparam logic [2:0] CFG_EXPERTS = 3'd3;
	localparam logic [2:0] CFG_TOPK    = 3'd4;
	localparam logic [2:0] CFG_ENABLE  = 3'd5;

	typedef enum logic [2:0] {
		OP_TOKEN = 3'd0,
		OP_ROUTE = 3'd1,
		OP_GATE  = 3'd2,
		OP_UP    = 3'd3,
		OP_DOWN  = 3'd4,
		OP_START = 3'd5,
		OP_READ  = 3'd6
	} opcode_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXP,
		ST_RTRD,
		ST_RTCHK,
		ST_ADV,
		ST_GU,
		ST_GU_DR,
		ST_ACT,
		ST_ACT_DR,
		ST_DN,
		ST_DN_DR,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		K_GU,
		K_ACT,
		K_DN
	} mac_kind_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [2:0]         expert_index;
		logic [3:0]         token_index;
		logic               slot_index;
		logic [5:0]         row_index;
		logic [5:0]         col_index;
		logic signed [15:0] data_value;
	} item_t;

	typedef struct packed {
		logic             valid;
		mac_kind_t        kind;
		logic             first;
		logic             last;
		logic [TOK_W-1:0] tok;
		logic [IDX_W-1:0] idx;
	} tag_t;

	typedef struct packed {
		tag_t                mac;
		logic [INTER_W-1:0]  kidx;
		logic [TOK_AW-1:0]   tok_addr;
		logic [WGT_AW-1:0]   wgt_addr;
		logic [ROUTE_AW-1:0] route_addr;
		logic                latch_w;
		logic                clr_we;
		logic [OUT_AW-1:0]   clr_addr;
		logic                load_en;
		logic                res_load_rd;
		logic                res_load_done;
	} cmd_t;

	typedef struct packed {
		logic       busy;
		logic [2:0] route_expert;
	} sts_t;

	typedef logic [255:0][12:0] sig_tab_t;

	// Shift-and-subtract quotient, used only while building the table.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Sigmoid table in Q0.12 over [-8,8), segments of 1/16, e^-x built in Q30.
	function automatic sig_tab_t build_sig();
		sig_tab_t   tab;
		logic [63:0] q;
		logic [63:0] den;
		logic [63:0] s;
		q = 64'd1040706261;
		for (int m = 0; m < 128; m++) begin
			den = (64'd1 << 30) + q;
			s = udiv64((64'd1 << 42) + (den >> 1), den);
			tab[128 + m] = s[12:0];
			tab[127 - m] = 13'(64'd4096 - s);
			q = (q * 64'd1008687096 + (64'd1 << 29)) >> 30;
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig();

	// Drop 12 fraction bits, round to nearest, ties away from zero.
	function automatic logic signed [28:0] rsh12(input logic signed [39:0] v);
		logic [39:0] mag;
		logic [28:0] m;
		mag = v[39] ? (~v + 40'd1) : v;
		mag = mag + 40'd2048;
		m = {1'b0, mag[39:12]};
		return v[39] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [15:0] rsat16(input logic signed [39:0] v);
		logic signed [28:0] r;
		r = rsh12(v);
		if (r > 29'sd32767)
			return 16'sh7fff;
		else if (r < -29'sd32768)
			return 16'sh8000;
		return r[15:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		if (v > 33'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -33'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

// ===== rtl/core/msef_if.sv =====
interface msef_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [2:0]  expert_index;
	logic [3:0]  token_index;
	logic        slot_index;
	logic [5:0]  row_index;
	logic [5:0]  col_index;
	logic signed [15:0] data_value;

	modport source (output valid, opcode, expert_index, token_index, slot_index,
		row_index, col_index, data_value, input ready);
	modport sink (input valid, opcode, expert_index, token_index, slot_index,
		row_index, col_index, data_value, output ready);
endinterface

interface msef_rsp_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic signed [31:0] out_value;

	modport source (output valid, result_kind, out_value, input ready);
	modport sink (input valid, result_kind, out_value, output ready);
endinterface

// ===== rtl/core/moe_swiglu_expert_ffn.sv =====
// Channel  Dir  Beat contents
// req      in   opcode, expert_index, token_index, slot_index, row_index, col_index, data_value
// rsp      out  result_kind, out_value
// cfg      in   cfg_write_en, cfg_index, cfg_data (plain write, no handshake)
//
// A load beat is taken whenever req.ready is high; a read beat passes through the output store
// read, then the result register, and req.ready stays low while the read is pending.
// A start beat clears the 1024-entry output store, then scans each expert and, unless it is
// disabled or a size is zero, each (slot, token) route entry; each token routed to it runs its
// gate/up, activation and down phases in the single shared multiply-accumulate pipeline.
// After reset the same clearing pass runs before req.ready rises.
// A result waits in the rsp register; a new beat is taken while it drains on rsp.ready.
module moe_swiglu_expert_ffn (
	input  logic        clk,
	input  logic        arst_n,
	msef_req_if.sink    req,
	msef_rsp_if.source  rsp,
	input  logic        cfg_write_en,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	`include "moe_swiglu_expert_ffn_macros.svh"

	msef_pkg::item_t item;
	msef_pkg::cmd_t  cmd;
	msef_pkg::sts_t  sts;
	logic signed [31:0] res_value;
	logic               rsp_kind;

	// Pack the request beat for the datapath load ports.
	assign item.opcode       = msef_pkg::opcode_t'(req.opcode);
	assign item.expert_index = req.expert_index;
	assign item.token_index  = req.token_index;
	assign item.slot_index   = req.slot_index;
	assign item.row_index    = req.row_index;
	assign item.col_index    = req.col_index;
	assign item.data_value   = req.data_value;

	// Sequencer: clearing pass, expert/slot/token scan, MAC phase ordering.
	msef_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req.valid),
		.req_opcode   (item.opcode),
		.req_ready    (req.ready),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.rsp_kind     (rsp_kind),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sts          (sts),
		.cmd          (cmd)
	);

	// Stores, the shared MAC pipeline, activation and output accumulate.
	msef_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.res_value (res_value)
	);

	assign rsp.result_kind = rsp_kind;
	assign rsp.out_value   = res_value;

	// Hold off new beats while any MAC stage is still in flight.
	`MSEF_ASSERT_NOW(a_ready_idle, req.ready, !sts.busy, "req ready while MAC pipe busy")
	// Done beats carry a zero value.
	`MSEF_ASSERT_NOW(a_done_zero, rsp.valid && rsp.result_kind, rsp.out_value == 32'sd0, "done nonzero")
	// A read beat shows up on rsp after the output store read and then the result register.
	`MSEF_ASSERT_NOW(a_read_lat, $past(req.valid && req.ready && req.opcode == msef_pkg::OP_READ, 2), rsp.valid, "read late")

endmodule

// ===== rtl/core/msef_datapath.sv =====
module msef_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  msef_pkg::item_t     item,
	input  msef_pkg::cmd_t      cmd,
	output msef_pkg::sts_t      sts,
	output logic signed [31:0]  res_value
);

	logic signed [15:0] token_mem [msef_pkg::MAX_TOKENS * msef_pkg::MAX_HIDDEN];
	logic [2:0]         rexp_mem  [msef_pkg::MAX_TOKENS * msef_pkg::MAX_TOPK];
	logic signed [15:0] rwgt_mem  [msef_pkg::MAX_TOKENS * msef_pkg::MAX_TOPK];
	logic signed [15:0] gate_mem  [msef_pkg::MAX_EXPERTS * msef_pkg::MAX_INTER * msef_pkg::MAX_HIDDEN];
	logic signed [15:0] up_mem    [msef_pkg::MAX_EXPERTS * msef_pkg::MAX_INTER * msef_pkg::MAX_HIDDEN];
	logic signed [15:0] down_mem  [msef_pkg::MAX_EXPERTS * msef_pkg::MAX_HIDDEN * msef_pkg::MAX_INTER];
	logic signed [15:0] act_mem   [msef_pkg::MAX_INTER];
	logic signed [15:0] gbuf_mem  [msef_pkg::MAX_INTER];
	logic signed [15:0] ubuf_mem  [msef_pkg::MAX_INTER];
	logic signed [31:0] out_mem   [msef_pkg::OUT_DEPTH];

	msef_pkg::tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	msef_pkg::tag_t tag_s3_dn;

	logic signed [15:0] tok_rd_s1, gate_rd_s1, up_rd_s1, down_rd_s1, act_rd_s1;
	logic signed [15:0] gb_rd_s1, ub_rd_s1;
	logic [2:0]         rexp_rd_q;
	logic signed [15:0] rwgt_rd_q, w_q;
	logic signed [31:0] pa_s2, pb_s2;
	logic signed [15:0] ub_s2;
	logic signed [39:0] acc_a_q, acc_b_q;
	logic signed [31:0] pc_s3;
	logic signed [15:0] y_s4;
	logic signed [31:0] out_rd_q, old_s5, wy_s5;

	logic [msef_pkg::TOK_AW-1:0]   tok_waddr;
	logic [msef_pkg::ROUTE_AW-1:0] route_waddr;
	logic [msef_pkg::WGT_AW-1:0]   wgt_waddr;
	logic [msef_pkg::OUT_AW-1:0]   out_raddr, out_waddr;
	logic                          out_we, dn_last_s3;
	logic signed [31:0]            out_wdata;
	logic signed [13:0]            sig_s1;
	logic signed [32:0]            out_sum;
	logic signed [28:0]            wy_rnd;

	assign tok_waddr   = {item.token_index, item.col_index};
	assign route_waddr = {item.token_index, item.slot_index};
	assign wgt_waddr   = {item.expert_index, item.row_index, item.col_index};
	assign sig_s1      = $signed({1'b0, msef_pkg::SIG_TAB[{~gb_rd_s1[15], gb_rd_s1[14:8]}]});

	assign dn_last_s3 = tag_s3.valid && tag_s3.kind == msef_pkg::K_DN && tag_s3.last;
	assign out_raddr  = dn_last_s3 ? {tag_s3.tok, tag_s3.idx[msef_pkg::HID_W-1:0]} : tok_waddr;

	// Only the last down beat of each output element moves on to stage 4.
	always_comb begin
		tag_s3_dn       = tag_s3;
		tag_s3_dn.valid = dn_last_s3;
	end

	assign wy_rnd  = msef_pkg::rsh12({{8{wy_s5[31]}}, wy_s5});
	assign out_sum = {old_s5[31], old_s5} + {{4{wy_rnd[28]}}, wy_rnd};

	always_comb begin
		out_we    = 1'b0;
		out_waddr = cmd.clr_addr;
		out_wdata = '0;
		if (cmd.clr_we) begin
			out_we = 1'b1;
		end else if (tag_s5.valid) begin
			out_we    = 1'b1;
			out_waddr = {tag_s5.tok, tag_s5.idx[msef_pkg::HID_W-1:0]};
			out_wdata = msef_pkg::sat32(out_sum);
		end
	end

	// Load ports and registered reads
	always_ff @(posedge clk) begin
		if (cmd.load_en && item.opcode == msef_pkg::OP_TOKEN) begin
			token_mem[tok_waddr] <= item.data_value;
		end
		tok_rd_s1 <= token_mem[cmd.tok_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_en && item.opcode == msef_pkg::OP_ROUTE) begin
			rexp_mem[route_waddr] <= item.expert_index;
			rwgt_mem[route_waddr] <= item.data_value;
		end
		rexp_rd_q <= rexp_mem[cmd.route_addr];
		rwgt_rd_q <= rwgt_mem[cmd.route_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_en && item.opcode == msef_pkg::OP_GATE) begin
			gate_mem[wgt_waddr] <= item.data_value;
		end
		gate_rd_s1 <= gate_mem[cmd.wgt_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_en && item.opcode == msef_pkg::OP_UP) begin
			up_mem[wgt_waddr] <= item.data_value;
		end
		up_rd_s1 <= up_mem[cmd.wgt_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_en && item.opcode == msef_pkg::OP_DOWN) begin
			down_mem[wgt_waddr] <= item.data_value;
		end
		down_rd_s1 <= down_mem[cmd.wgt_addr];
	end

	always_ff @(posedge clk) begin
		if (tag_s3.valid && tag_s3.kind == msef_pkg::K_GU && tag_s3.last) begin
			gbuf_mem[tag_s3.idx[msef_pkg::INTER_W-1:0]] <= msef_pkg::rsat16(acc_a_q);
			ubuf_mem[tag_s3.idx[msef_pkg::INTER_W-1:0]] <= msef_pkg::rsat16(acc_b_q);
		end
		gb_rd_s1 <= gbuf_mem[cmd.mac.idx[msef_pkg::INTER_W-1:0]];
		ub_rd_s1 <= ubuf_mem[cmd.mac.idx[msef_pkg::INTER_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (tag_s3.valid && tag_s3.kind == msef_pkg::K_ACT) begin
			act_mem[tag_s3.idx[msef_pkg::INTER_W-1:0]] <=
				msef_pkg::rsat16({{8{pc_s3[31]}}, pc_s3});
		end
		act_rd_s1 <= act_mem[cmd.kidx];
	end

	always_ff @(posedge clk) begin
		if (out_we) begin
			out_mem[out_waddr] <= out_wdata;
		end
		out_rd_q <= out_mem[out_raddr];
	end

	// Stage tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else begin
			tag_s1 <= cmd.mac;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3_dn;
			tag_s5 <= tag_s4;
		end
	end

	// Arithmetic stages
	always_ff @(posedge clk) begin
		case (tag_s1.kind)
			msef_pkg::K_GU: begin
				pa_s2 <= tok_rd_s1 * gate_rd_s1;
				pb_s2 <= tok_rd_s1 * up_rd_s1;
			end
			msef_pkg::K_ACT: begin
				pa_s2 <= gb_rd_s1 * sig_s1;
				pb_s2 <= '0;
			end
			msef_pkg::K_DN: begin
				pa_s2 <= act_rd_s1 * down_rd_s1;
				pb_s2 <= '0;
			end
			default: begin
				pa_s2 <= '0;
				pb_s2 <= '0;
			end
		endcase
		ub_s2 <= ub_rd_s1;

		if (tag_s2.valid && tag_s2.kind != msef_pkg::K_ACT) begin
			if (tag_s2.first) begin
				acc_a_q <= {{8{pa_s2[31]}}, pa_s2};
				acc_b_q <= {{8{pb_s2[31]}}, pb_s2};
			end else begin
				acc_a_q <= acc_a_q + {{8{pa_s2[31]}}, pa_s2};
				acc_b_q <= acc_b_q + {{8{pb_s2[31]}}, pb_s2};
			end
		end
		pc_s3 <= msef_pkg::rsat16({{8{pa_s2[31]}}, pa_s2}) * ub_s2;

		y_s4   <= msef_pkg::rsat16(acc_a_q);
		wy_s5  <= w_q * y_s4;
		old_s5 <= out_rd_q;

		if (cmd.latch_w) begin
			w_q <= rwgt_rd_q;
		end

		if (cmd.res_load_rd) begin
			res_value <= out_rd_q;
		end else if (cmd.res_load_done) begin
			res_value <= '0;
		end
	end

	assign sts.busy = tag_s1.valid | tag_s2.valid | tag_s3.valid | tag_s4.valid | tag_s5.valid;
	assign sts.route_expert = rexp_rd_q;

endmodule

// ===== rtl/core/msef_ctrl.sv =====
module msef_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  msef_pkg::opcode_t req_opcode,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic              rsp_kind,
	input  logic              cfg_write_en,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  msef_pkg::sts_t    sts,
	output msef_pkg::cmd_t    cmd
);

	msef_pkg::state_t state_q, state_d;

	logic [4:0] tokens_q;
	logic [6:0] hidden_q, inter_q;
	logic [3:0] experts_q;
	logic [1:0] topk_q;
	logic [7:0] enable_q;

	logic [3:0]                     e_q, e_d;
	logic [msef_pkg::SLOT_W-1:0]    j_q, j_d;
	logic [msef_pkg::TOK_W-1:0]     t_q, t_d;
	logic [msef_pkg::INTER_W-1:0]   i_q, i_d;
	logic [msef_pkg::HID_W-1:0]     h_q, h_d, o_q, o_d;
	logic [msef_pkg::OUT_AW-1:0]    clr_q, clr_d;
	logic                           run_q, run_d, rd_pend_q, rd_pend_d;
	logic                           rsp_valid_q, rsp_valid_d, rsp_kind_q, rsp_kind_d;

	logic [4:0] nt;
	logic [6:0] nh, ni;
	logic [3:0] ne;
	logic [1:0] nk;
	logic       accept, h_last, i_last, o_last, skip, res_free;

	assign nt = (tokens_q  > 5'(msef_pkg::MAX_TOKENS))  ? 5'(msef_pkg::MAX_TOKENS)  : tokens_q;
	assign nh = (hidden_q  > 7'(msef_pkg::MAX_HIDDEN))  ? 7'(msef_pkg::MAX_HIDDEN)  : hidden_q;
	assign ni = (inter_q   > 7'(msef_pkg::MAX_INTER))   ? 7'(msef_pkg::MAX_INTER)   : inter_q;
	assign ne = (experts_q > 4'(msef_pkg::MAX_EXPERTS)) ? 4'(msef_pkg::MAX_EXPERTS) : experts_q;
	assign nk = (topk_q    > 2'(msef_pkg::MAX_TOPK))    ? 2'(msef_pkg::MAX_TOPK)    : topk_q;

	assign h_last = 7'(h_q) == nh - 7'd1;
	assign i_last = 7'(i_q) == ni - 7'd1;
	assign o_last = 7'(o_q) == nh - 7'd1;
	assign skip   = (e_q < 4'd8 && !enable_q[e_q[2:0]]) || nt == 5'd0 || nk == 2'd0 ||
		nh == 7'd0 || ni == 7'd0;
	assign res_free = !rsp_valid_q || rsp_ready;
	assign accept   = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tokens_q  <= 5'd16;
			hidden_q  <= 7'd64;
			inter_q   <= 7'd64;
			experts_q <= 4'd8;
			topk_q    <= 2'd2;
			enable_q  <= 8'hff;
		end else if (cfg_write_en) begin
			case (cfg_index)
				msef_pkg::CFG_TOKENS:  tokens_q  <= cfg_data[4:0];
				msef_pkg::CFG_HIDDEN:  hidden_q  <= cfg_data[6:0];
				msef_pkg::CFG_INTER:   inter_q   <= cfg_data[6:0];
				msef_pkg::CFG_EXPERTS: experts_q <= cfg_data[3:0];
				msef_pkg::CFG_TOPK:    topk_q    <= cfg_data[1:0];
				msef_pkg::CFG_ENABLE:  enable_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msef_pkg::ST_CLEAR;
			e_q         <= '0;
			j_q         <= '0;
			t_q         <= '0;
			i_q         <= '0;
			h_q         <= '0;
			o_q         <= '0;
			clr_q       <= '0;
			run_q       <= 1'b0;
			rd_pend_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_kind_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			e_q         <= e_d;
			j_q         <= j_d;
			t_q         <= t_d;
			i_q         <= i_d;
			h_q         <= h_d;
			o_q         <= o_d;
			clr_q       <= clr_d;
			run_q       <= run_d;
			rd_pend_q   <= rd_pend_d;
			rsp_valid_q <= rsp_valid_d;
			rsp_kind_q  <= rsp_kind_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		e_d       = e_q;
		j_d       = j_q;
		t_d       = t_q;
		i_d       = i_q;
		h_d       = h_q;
		o_d       = o_q;
		clr_d     = clr_q;
		run_d     = run_q;
		rd_pend_d = 1'b0;
		req_ready = 1'b0;
		cmd       = '0;
		cmd.mac.tok = t_q;

		case (state_q)
			msef_pkg::ST_CLEAR: begin
				cmd.clr_we   = 1'b1;
				cmd.clr_addr = clr_q;
				clr_d = clr_q + 1'b1;
				if (32'(clr_q) == msef_pkg::OUT_DEPTH - 1) begin
					clr_d = '0;
					if (run_q) begin
						run_d   = 1'b0;
						e_d     = '0;
						state_d = msef_pkg::ST_EXP;
					end else begin
						state_d = msef_pkg::ST_IDLE;
					end
				end
			end
			msef_pkg::ST_IDLE: begin
				req_ready   = !rd_pend_q && res_free;
				cmd.load_en = accept;
				if (accept) begin
					case (req_opcode)
						msef_pkg::OP_START: begin
							run_d   = 1'b1;
							state_d = msef_pkg::ST_CLEAR;
						end
						msef_pkg::OP_READ: rd_pend_d = 1'b1;
						default: ;
					endcase
				end
			end
			msef_pkg::ST_EXP: begin
				if (e_q >= ne) begin
					state_d = msef_pkg::ST_DONE;
				end else if (skip) begin
					e_d = e_q + 4'd1;
				end else begin
					j_d     = '0;
					t_d     = '0;
					state_d = msef_pkg::ST_RTRD;
				end
			end
			msef_pkg::ST_RTRD: begin
				cmd.route_addr = {t_q, j_q};
				state_d = msef_pkg::ST_RTCHK;
			end
			msef_pkg::ST_RTCHK: begin
				cmd.latch_w = 1'b1;
				if ({1'b0, sts.route_expert} == e_q) begin
					i_d     = '0;
					h_d     = '0;
					state_d = msef_pkg::ST_GU;
				end else begin
					state_d = msef_pkg::ST_ADV;
				end
			end
			msef_pkg::ST_ADV: begin
				if ({1'b0, t_q} == nt - 5'd1) begin
					t_d = '0;
					if ({1'b0, j_q} == nk - 2'd1) begin
						j_d     = '0;
						e_d     = e_q + 4'd1;
						state_d = msef_pkg::ST_EXP;
					end else begin
						j_d     = j_q + 1'b1;
						state_d = msef_pkg::ST_RTRD;
					end
				end else begin
					t_d     = t_q + 1'b1;
					state_d = msef_pkg::ST_RTRD;
				end
			end
			msef_pkg::ST_GU: begin
				cmd.mac.valid = 1'b1;
				cmd.mac.kind  = msef_pkg::K_GU;
				cmd.mac.first = h_q == '0;
				cmd.mac.last  = h_last;
				cmd.mac.idx   = msef_pkg::IDX_W'(i_q);
				cmd.tok_addr  = {t_q, h_q};
				cmd.wgt_addr  = {e_q[msef_pkg::EXP_W-1:0], i_q, h_q};
				if (h_last) begin
					h_d = '0;
					if (i_last) begin
						i_d     = '0;
						state_d = msef_pkg::ST_GU_DR;
					end else begin
						i_d = i_q + 1'b1;
					end
				end else begin
					h_d = h_q + 1'b1;
				end
			end
			msef_pkg::ST_GU_DR: begin
				if (!sts.busy) begin
					state_d = msef_pkg::ST_ACT;
				end
			end
			msef_pkg::ST_ACT: begin
				cmd.mac.valid = 1'b1;
				cmd.mac.kind  = msef_pkg::K_ACT;
				cmd.mac.idx   = msef_pkg::IDX_W'(i_q);
				if (i_last) begin
					i_d     = '0;
					state_d = msef_pkg::ST_ACT_DR;
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			msef_pkg::ST_ACT_DR: begin
				if (!sts.busy) begin
					o_d     = '0;
					i_d     = '0;
					state_d = msef_pkg::ST_DN;
				end
			end
			msef_pkg::ST_DN: begin
				cmd.mac.valid = 1'b1;
				cmd.mac.kind  = msef_pkg::K_DN;
				cmd.mac.first = i_q == '0;
				cmd.mac.last  = i_last;
				cmd.mac.idx   = msef_pkg::IDX_W'(o_q);
				cmd.kidx      = i_q;
				cmd.wgt_addr  = {e_q[msef_pkg::EXP_W-1:0], o_q, i_q};
				if (i_last) begin
					i_d = '0;
					if (o_last) begin
						o_d     = '0;
						state_d = msef_pkg::ST_DN_DR;
					end else begin
						o_d = o_q + 1'b1;
					end
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			msef_pkg::ST_DN_DR: begin
				if (!sts.busy) begin
					state_d = msef_pkg::ST_ADV;
				end
			end
			msef_pkg::ST_DONE: begin
				if (res_free) begin
					cmd.res_load_done = 1'b1;
					state_d = msef_pkg::ST_IDLE;
				end
			end
			default: state_d = msef_pkg::ST_IDLE;
		endcase

		cmd.res_load_rd = rd_pend_q;
		rsp_valid_d = (rsp_valid_q && !rsp_ready) || cmd.res_load_rd || cmd.res_load_done;
		rsp_kind_d  = rsp_kind_q;
		if (cmd.res_load_rd) begin
			rsp_kind_d = 1'b0;
		end else if (cmd.res_load_done) begin
			rsp_kind_d = 1'b1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_kind  = rsp_kind_q;

endmodule

// ===== sim/msef_ffn_checker.sv =====
import msef_pkg::*;

module msef_ffn_checker (
	input  logic        clk,
	input  logic        arst_n,
	msef_req_if         req,
	msef_rsp_if         rsp,
	input  logic        cfg_write_en,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          errors,
	output int          pending
);

	typedef struct {
		logic               kind;
		logic signed [31:0] value;
	} ffn_result_t;

	ffn_result_t awaited_q[$];

	logic [4:0] reg_tokens;
	logic [6:0] reg_hidden;
	logic [6:0] reg_inter;
	logic [3:0] reg_experts;
	logic [1:0] reg_topk;
	logic [7:0] reg_enable;

	logic signed [15:0] tok_mem[MAX_TOKENS*MAX_HIDDEN];
	logic [2:0]         rt_exp_mem[MAX_TOKENS*MAX_TOPK];
	logic signed [15:0] rt_wgt_mem[MAX_TOKENS*MAX_TOPK];
	logic signed [15:0] gate_mem[MAX_EXPERTS*MAX_INTER*MAX_HIDDEN];
	logic signed [15:0] up_mem[MAX_EXPERTS*MAX_INTER*MAX_HIDDEN];
	logic signed [15:0] down_mem[MAX_EXPERTS*MAX_HIDDEN*MAX_INTER];
	logic signed [31:0] acc_mem[MAX_TOKENS*MAX_HIDDEN];
	logic [12:0]        sigmoid_lut[256];

	function automatic longint round_q12(input longint v);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + 2048) >>> 12;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint clip16(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic int lim(input int v, input int hi);
		return (v > hi) ? hi : v;
	endfunction

	function automatic longint silu_q12(input longint g);
		logic [15:0] biased;
		biased = 16'(g + 32768);
		return clip16(round_q12(g * longint'(sigmoid_lut[biased[15:8]])));
	endfunction

	// Mixture-of-experts pass over the whole output store
	task automatic run_experts();
		int nt, nh, ni, ne, nk, r, b;
		longint ag, au, acc, y, w;
		longint gate_v[MAX_INTER];
		longint up_v[MAX_INTER];
		longint act_v[MAX_INTER];
		nt = lim(reg_tokens, MAX_TOKENS);
		nh = lim(reg_hidden, MAX_HIDDEN);
		ni = lim(reg_inter, MAX_INTER);
		ne = lim(reg_experts, MAX_EXPERTS);
		nk = lim(reg_topk, MAX_TOPK);
		foreach (acc_mem[k])
			acc_mem[k] = '0;
		for (int e = 0; e < ne; e++) begin
			if (!reg_enable[e])
				continue;
			for (int j = 0; j < nk; j++)
				for (int t = 0; t < nt; t++) begin
					r = t * MAX_TOPK + j;
					if (rt_exp_mem[r] != 3'(e))
						continue;
					for (int i = 0; i < ni; i++) begin
						ag = 0;
						au = 0;
						b = (e * MAX_INTER + i) * MAX_HIDDEN;
						for (int h = 0; h < nh; h++) begin
							ag += longint'(tok_mem[t*MAX_HIDDEN+h]) * gate_mem[b+h];
							au += longint'(tok_mem[t*MAX_HIDDEN+h]) * up_mem[b+h];
						end
						gate_v[i] = clip16(round_q12(ag));
						up_v[i] = clip16(round_q12(au));
					end
					for (int i = 0; i < ni; i++)
						act_v[i] = clip16(round_q12(silu_q12(gate_v[i]) * up_v[i]));
					w = rt_wgt_mem[r];
					for (int o = 0; o < nh; o++) begin
						acc = 0;
						b = (e * MAX_HIDDEN + o) * MAX_INTER;
						for (int i = 0; i < ni; i++)
							acc += act_v[i] * down_mem[b+i];
						y = clip16(round_q12(acc));
						acc_mem[t*MAX_HIDDEN+o] = 32'(clip32(
							longint'(acc_mem[t*MAX_HIDDEN+o]) + round_q12(w * y)));
					end
				end
		end
	endtask

	initial begin
		longint q, den, s;
		q = 1040706261;
		for (int m = 0; m < 128; m++) begin
			den = (64'sd1 << 30) + q;
			s = ((64'sd1 << 42) + den / 2) / den;
			sigmoid_lut[128+m] = 13'(s);
			sigmoid_lut[127-m] = 13'(4096 - s);
			q = (q * 1008687096 + (64'sd1 << 29)) >>> 30;
		end
		foreach (tok_mem[k]) tok_mem[k] = '0;
		foreach (rt_exp_mem[k]) rt_exp_mem[k] = '0;
		foreach (rt_wgt_mem[k]) rt_wgt_mem[k] = '0;
		foreach (gate_mem[k]) gate_mem[k] = '0;
		foreach (up_mem[k]) up_mem[k] = '0;
		foreach (down_mem[k]) down_mem[k] = '0;
	end

	always @(posedge clk or negedge arst_n) begin
		ffn_result_t got, want;
		if (!arst_n) begin
			reg_tokens = 5'd16;
			reg_hidden = 7'd64;
			reg_inter = 7'd64;
			reg_experts = 4'd8;
			reg_topk = 2'd2;
			reg_enable = 8'hff;
			foreach (acc_mem[k])
				acc_mem[k] = '0;
			awaited_q.delete();
			errors = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.kind = rsp.result_kind;
				got.value = rsp.out_value;
				if (awaited_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat kind %0d value %0d", $time,
						got.kind, got.value);
				end else begin
					want = awaited_q.pop_front();
					if (got.kind !== want.kind) begin
						errors++;
						$display("%0t: result_kind expected %0d actual %0d", $time,
							want.kind, got.kind);
					end
					if (got.value !== want.value) begin
						errors++;
						$display("%0t: out_value expected %0d actual %0d", $time,
							want.value, got.value);
					end
				end
			end
			if (cfg_write_en) begin
				case (cfg_index)
					CFG_TOKENS:  reg_tokens = cfg_data[4:0];
					CFG_HIDDEN:  reg_hidden = cfg_data[6:0];
					CFG_INTER:   reg_inter = cfg_data[6:0];
					CFG_EXPERTS: reg_experts = cfg_data[3:0];
					CFG_TOPK:    reg_topk = cfg_data[1:0];
					CFG_ENABLE:  reg_enable = cfg_data;
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				case (opcode_t'(req.opcode))
					OP_TOKEN: tok_mem[{req.token_index, req.col_index}] = req.data_value;
					OP_ROUTE: begin
						rt_exp_mem[{req.token_index, req.slot_index}] = req.expert_index;
						rt_wgt_mem[{req.token_index, req.slot_index}] = req.data_value;
					end
					OP_GATE: gate_mem[{req.expert_index, req.row_index, req.col_index}] =
						req.data_value;
					OP_UP: up_mem[{req.expert_index, req.row_index, req.col_index}] =
						req.data_value;
					OP_DOWN: down_mem[{req.expert_index, req.row_index, req.col_index}] =
						req.data_value;
					OP_START: begin
						run_experts();
						awaited_q.push_back('{1'b1, 32'sd0});
					end
					OP_READ: awaited_q.push_back('{1'b0,
						acc_mem[{req.token_index, req.col_index}]});
					default: ;
				endcase
			end
		end
		pending = awaited_q.size();
	end

endmodule

// ===== sim/testbench.sv =====
import msef_pkg::*;

module testbench;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int ITEM_TARGET = 600;

	logic       clk;
	logic       arst_n;
	logic       cfg_write_en;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;
	int         errors;
	int         pending;

	msef_req_if req();
	msef_rsp_if rsp();

	moe_swiglu_expert_ffn dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	msef_ffn_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.pending     (pending)
	);

	// Mirror of what the stimulus has loaded, so that a start never touches
	// a store entry that was never written.
	bit       tok_loaded[MAX_TOKENS*MAX_HIDDEN];
	bit       rt_loaded[MAX_TOKENS*MAX_TOPK];
	bit [2:0] rt_target[MAX_TOKENS*MAX_TOPK];
	bit       gate_loaded[MAX_EXPERTS*MAX_INTER*MAX_HIDDEN];
	bit       up_loaded[MAX_EXPERTS*MAX_INTER*MAX_HIDDEN];
	bit       down_loaded[MAX_EXPERTS*MAX_HIDDEN*MAX_INTER];

	// Register values as last written
	int sh_tokens, sh_hidden, sh_inter, sh_experts, sh_topk;
	bit [7:0] sh_enable;

	int beats_sent;
	int burst_left;
	int hold_req;
	int hold_seen;
	int hold_left;
	int run_left;
	bit rx_open;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Receiver: alternating open and stalled runs of random length, plus a long
	// hold-off whenever the stimulus asks for one.
	initial begin
		rsp.ready = 1'b0;
		hold_seen = 0;
		hold_left = 0;
		run_left = 0;
		rx_open = 1'b1;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					rx_open = ~rx_open;
					run_left = rx_open ? $urandom_range(1, 40) : $urandom_range(1, 6);
				end
				run_left--;
				rsp.ready <= rx_open;
			end
		end
	end

	// Offer one beat and hold it until accepted. Called at a rising edge;
	// returns at the edge that took the beat, with valid still high.
	task automatic send_beat(input item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid        <= 1'b1;
		req.opcode       <= it.opcode;
		req.expert_index <= it.expert_index;
		req.token_index  <= it.token_index;
		req.slot_index   <= it.slot_index;
		req.row_index    <= it.row_index;
		req.col_index    <= it.col_index;
		req.data_value   <= it.data_value;
		do
			@(negedge clk);
		while (!req.ready);
		@(posedge clk);
		beats_sent++;
	endtask

	// Drop valid and wait until every predicted result has drained.
	task automatic drain();
		req.valid <= 1'b0;
		burst_left = 0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	function automatic item_t blank_item(input opcode_t op);
		item_t it;
		it = '0;
		it.opcode = op;
		return it;
	endfunction

	task automatic load_token(input int t, input int h, input logic signed [15:0] d);
		item_t it;
		it = blank_item(OP_TOKEN);
		it.token_index = 4'(t);
		it.col_index = 6'(h);
		it.data_value = d;
		tok_loaded[t*MAX_HIDDEN+h] = 1'b1;
		send_beat(it);
	endtask

	task automatic load_route(input int t, input int j, input int e,
			input logic signed [15:0] d);
		item_t it;
		it = blank_item(OP_ROUTE);
		it.token_index = 4'(t);
		it.slot_index = 1'(j);
		it.expert_index = 3'(e);
		it.data_value = d;
		rt_loaded[t*MAX_TOPK+j] = 1'b1;
		rt_target[t*MAX_TOPK+j] = 3'(e);
		send_beat(it);
	endtask

	task automatic load_weight(input opcode_t op, input int e, input int row, input int col,
			input logic signed [15:0] d);
		item_t it;
		int a;
		it = blank_item(op);
		it.expert_index = 3'(e);
		it.row_index = 6'(row);
		it.col_index = 6'(col);
		it.data_value = d;
		a = (e * 64 + row) * 64 + col;
		case (op)
			OP_GATE: gate_loaded[a] = 1'b1;
			OP_UP:   up_loaded[a] = 1'b1;
			default: down_loaded[a] = 1'b1;
		endcase
		send_beat(it);
	endtask

	task automatic read_out(input int t, input int h);
		item_t it;
		it = blank_item(OP_READ);
		it.token_index = 4'(t);
		it.col_index = 6'(h);
		send_beat(it);
	endtask

	function automatic logic signed [15:0] rand_data();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 8191)) - 16'sd4096;
			default: return 16'($urandom);
		endcase
	endfunction

	// Fill whatever the next start will read, then launch it.
	task automatic start_pass();
		int nt, nh, ni, ne, nk, r;
		bit used[MAX_EXPERTS];
		nt = (sh_tokens > MAX_TOKENS) ? MAX_TOKENS : sh_tokens;
		nh = (sh_hidden > MAX_HIDDEN) ? MAX_HIDDEN : sh_hidden;
		ni = (sh_inter > MAX_INTER) ? MAX_INTER : sh_inter;
		ne = (sh_experts > MAX_EXPERTS) ? MAX_EXPERTS : sh_experts;
		nk = (sh_topk > MAX_TOPK) ? MAX_TOPK : sh_topk;
		foreach (used[e])
			used[e] = 1'b0;
		for (int t = 0; t < nt; t++)
			for (int j = 0; j < nk; j++) begin
				r = t * MAX_TOPK + j;
				if (!rt_loaded[r])
					load_route(t, j, $urandom_range(0, 7), rand_data());
				if (rt_target[r] < ne && sh_enable[rt_target[r]]) begin
					used[rt_target[r]] = 1'b1;
					for (int h = 0; h < nh; h++)
						if (!tok_loaded[t*MAX_HIDDEN+h])
							load_token(t, h, rand_data());
				end
			end
		for (int e = 0; e < MAX_EXPERTS; e++) begin
			if (!used[e])
				continue;
			for (int i = 0; i < ni; i++)
				for (int h = 0; h < nh; h++) begin
					if (!gate_loaded[(e*64+i)*64+h])
						load_weight(OP_GATE, e, i, h, rand_data());
					if (!up_loaded[(e*64+i)*64+h])
						load_weight(OP_UP, e, i, h, rand_data());
					if (!down_loaded[(e*64+h)*64+i])
						load_weight(OP_DOWN, e, h, i, rand_data());
				end
		end
		send_beat(blank_item(OP_START));
	endtask

	task automatic set_reg(input logic [2:0] idx, input int v);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 8'(v);
		@(posedge clk);
	endtask

	// Write all six registers; only called when no start pass is in flight.
	task automatic configure(input int nt, input int nh, input int ni, input int ne,
			input int nk, input int en);
		sh_tokens = nt & 31;
		sh_hidden = nh & 127;
		sh_inter = ni & 127;
		sh_experts = ne & 15;
		sh_topk = nk & 3;
		sh_enable = 8'(en);
		set_reg(CFG_TOKENS, nt);
		set_reg(CFG_HIDDEN, nh);
		set_reg(CFG_INTER, ni);
		set_reg(CFG_EXPERTS, ne);
		set_reg(CFG_TOPK, nk);
		set_reg(CFG_ENABLE, en);
		cfg_write_en <= 1'b0;
	endtask

	// Random traffic for one phase: mostly loads and reads, with starts that
	// run complete passes, and some opcode-seven noise.
	task automatic random_traffic(input int count);
		item_t it;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: load_weight(opcode_t'($urandom_range(OP_GATE, OP_DOWN)),
					$urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 63),
					rand_data());
				5, 6: load_token($urandom_range(0, 15), $urandom_range(0, 63), rand_data());
				7: load_route($urandom_range(0, 15), $urandom_range(0, 1),
					$urandom_range(0, 7), rand_data());
				8: start_pass();
				9: begin
					it = item_t'({$urandom, $urandom});
					it.opcode = opcode_t'(3'd7);
					send_beat(it);
				end
				default: read_out($urandom_range(0, 15), $urandom_range(0, 63));
			endcase
		end
	endtask

	// Start, then read back up to the first six rows and five columns that can hold data, plus four random spots.
	task automatic pass_and_readback();
		int nt, nh;
		start_pass();
		nt = (sh_tokens > MAX_TOKENS) ? MAX_TOKENS : sh_tokens;
		nh = (sh_hidden > MAX_HIDDEN) ? MAX_HIDDEN : sh_hidden;
		for (int t = 0; t < nt && t < 6; t++)
			for (int h = 0; h < nh && h < 5; h++)
				read_out(t, h);
		repeat (4)
			read_out($urandom_range(0, 15), $urandom_range(0, 63));
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.opcode = '0;
		req.expert_index = '0;
		req.token_index = '0;
		req.slot_index = '0;
		req.row_index = '0;
		req.col_index = '0;
		req.data_value = '0;
		cfg_write_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_req = 0;
		beats_sent = 0;
		burst_left = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme data on every store, noise opcode, then a pass.
		configure(2, 2, 2, 8, 2, 8'hff);
		load_token(0, 0, 16'sh7fff);
		load_token(0, 1, 16'sh8000);
		load_token(1, 0, 16'sh8000);
		load_token(1, 1, 16'sh7fff);
		load_route(0, 0, 7, 16'sh7fff);
		load_route(0, 1, 0, 16'sh8000);
		load_route(1, 0, 0, 16'sh1000);
		load_route(1, 1, 7, -16'sh1000);
		load_weight(OP_GATE, 7, 0, 0, 16'sh7fff);
		load_weight(OP_UP, 7, 0, 0, 16'sh8000);
		load_weight(OP_DOWN, 7, 0, 0, 16'sh7fff);
		load_weight(OP_GATE, 0, 1, 1, 16'sh8000);
		load_weight(OP_UP, 0, 63, 63, 16'sh7fff);
		load_weight(OP_DOWN, 0, 63, 63, 16'sh8000);
		send_beat(item_t'({3'd7, 3'd7, 4'd15, 1'b1, 6'd63, 6'd63, 16'shffff}));
		read_out(15, 63);
		pass_and_readback();

		// Corner settings first, then random ones until the item budget is spent.
		phase = 0;
		while (beats_sent < ITEM_TARGET) begin
			drain();
			case (phase)
				0: configure(0, 4, 4, 8, 2, 8'hff);
				1: configure(16, 0, 3, 8, 2, 8'hff);
				2: configure(4, 3, 0, 8, 2, 8'hff);
				3: configure(4, 3, 3, 0, 2, 8'hff);
				4: configure(4, 3, 3, 8, 0, 8'hff);
				5: configure(4, 3, 3, 8, 2, 8'h00);
				6: configure(1, 127, 1, 15, 3, 8'h02);
				7: configure(1, 1, 127, 8, 1, 8'ha5);
				8: configure(31, 2, 2, 8, 2, 8'hff);
				default: configure($urandom_range(0, 31), $urandom_range(1, 5),
					$urandom_range(1, 5), $urandom_range(0, 15), $urandom_range(0, 3),
					$urandom_range(0, 255));
			endcase
			if (phase == 0) begin
				// Long receiver hold-off with reads still streaming in: the result
				// path backs up and the block must stall req.
				hold_req++;
				repeat (30)
					read_out($urandom_range(0, 15), $urandom_range(0, 63));
			end
			random_traffic(30);
			if (phase == 1) begin
				// Sender pauses mid-phase until everything has come back.
				drain();
			end
			pass_and_readback();
			phase++;
		end

		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/msef_pkg.sv
rtl/core/msef_if.sv
rtl/core/msef_datapath.sv
rtl/core/msef_ctrl.sv
rtl/core/moe_swiglu_expert_ffn.sv
sim/msef_ffn_checker.sv
sim/testbench.sv
